>>> sv/serial_frame_deframer_unit_assert.svh
// ---------------------------------------------------------------------------
// Serial frame deframer assertion macros
// Shared property forms for the deframer's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

>>> sv/sfd_pkg.sv
// ---------------------------------------------------------------------------
// Serial frame deframer package
// Constants, state type and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package sfd_pkg;

  // Frame buffer depth, its fill counter width, and the count and index widths.
  localparam int MAX_FRAME     = 64;
  localparam int FILL_W        = $clog2(MAX_FRAME);
  localparam int CNT_W         = 8;
  localparam int IDX_OUT_W     = 6;

  // Special byte values and frame layout.
  localparam logic [7:0] SYNC_BYTE     = 8'hEF;
  localparam logic [7:0] END_BYTE      = 8'hFF;
  localparam int         PAYLOAD_START = 8;
  localparam int         LEN_OFFSET    = 5;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } sfd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic idx_inc;
  } sfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_end;
    logic empty;
    logic idx_last;
  } sfd_sts_t;

endpackage

>>> sv/sfd_dp.sv
// ---------------------------------------------------------------------------
// Serial frame deframer datapath
// Frame buffer memory, fill counter, header registers and payload readout.
// ---------------------------------------------------------------------------
module sfd_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_rx_byte,
  input  sfd_pkg::sfd_cmd_t cmd,
  output sfd_pkg::sfd_sts_t sts,
  output logic [7:0]        reserved_byte,
  output logic [7:0]        addr_first,
  output logic [7:0]        addr_second,
  output logic [7:0]        frame_length,
  output logic [7:0]        node_id,
  output logic [7:0]        device_id,
  output logic [7:0]        payload_byte,
  output logic [5:0]        payload_index,
  output logic              payload_valid,
  output logic              last
);
  import sfd_pkg::*;

  logic [7:0]        mem [MAX_FRAME];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        last_byte_r;
  logic [7:0]        hdr2_r, hdr3_r, hdr4_r, hdr5_r, hdr6_r, hdr7_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              empty_r, empty_nxt;
  logic [7:0]        rd_data_r;
  logic [FILL_W-1:0] rd_addr;
  logic              resync;
  logic              frame_end;
  logic [8:0]        fill_plus1;

  // Classify the incoming byte against the frame held so far.
  assign fill_plus1 = 9'(fill_r) + 9'd1;
  assign resync     = (in_rx_byte == SYNC_BYTE) && (fill_r != '0) &&
                      (last_byte_r == SYNC_BYTE);
  assign frame_end  = (fill_r > FILL_W'(LEN_OFFSET)) &&
                      (fill_plus1 == {1'b0, hdr5_r}) && (in_rx_byte == END_BYTE);

  // Next fill count, payload count and readout index.
  always_comb begin
    fill_nxt  = fill_r;
    count_nxt = count_r;
    empty_nxt = empty_r;
    idx_nxt   = idx_r;
    if (cmd.accept) begin
      if (resync) begin
        fill_nxt = FILL_W'(2);
      end else if (frame_end) begin
        fill_nxt = '0;
        idx_nxt  = '0;
        if (hdr5_r > 8'(PAYLOAD_START + 1)) begin
          count_nxt = hdr5_r - 8'(PAYLOAD_START + 1);
          empty_nxt = 1'b0;
        end else begin
          count_nxt = '0;
          empty_nxt = 1'b1;
        end
      end else if (fill_r == FILL_W'(MAX_FRAME - 1)) begin
        fill_nxt = '0;
      end else begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      idx_r   <= '0;
      count_r <= '0;
      empty_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      empty_r <= empty_nxt;
    end
  end

  // Last held byte and header bytes at offsets two to seven.
  always_ff @(posedge clk) begin
    if (cmd.accept && !resync) begin
      last_byte_r <= in_rx_byte;
      case (fill_r)
        FILL_W'(2): hdr2_r <= in_rx_byte;
        FILL_W'(3): hdr3_r <= in_rx_byte;
        FILL_W'(4): hdr4_r <= in_rx_byte;
        FILL_W'(5): hdr5_r <= in_rx_byte;
        FILL_W'(6): hdr6_r <= in_rx_byte;
        FILL_W'(7): hdr7_r <= in_rx_byte;
        default: ;
      endcase
    end else if (cmd.accept) begin
      last_byte_r <= SYNC_BYTE;
    end
  end

  // Frame buffer: one write port for received bytes, one registered read port.
  assign rd_addr = FILL_W'(PAYLOAD_START) + idx_r[FILL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept && !resync && !frame_end) begin
      mem[fill_r] <= in_rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Status back to the controller.
  assign sts.frame_end = frame_end;
  assign sts.empty     = empty_r;
  assign sts.idx_last  = (idx_r + CNT_W'(1)) == count_r;

  // Result fields; offset seven is absent from a frame of length seven.
  assign reserved_byte = hdr2_r;
  assign addr_first    = hdr3_r;
  assign addr_second   = hdr4_r;
  assign frame_length  = hdr5_r;
  assign node_id       = hdr6_r;
  assign device_id     = (hdr5_r == 8'd7) ? 8'd0 : hdr7_r;
  assign payload_byte  = empty_r ? 8'd0 : rd_data_r;
  assign payload_index = empty_r ? '0 : idx_r[IDX_OUT_W-1:0];
  assign payload_valid = !empty_r;
  assign last          = empty_r || sts.idx_last;

endmodule

>>> sv/sfd_ctrl.sv
// ---------------------------------------------------------------------------
// Serial frame deframer controller
// Sequences byte intake and the readout of a completed frame's payload.
// ---------------------------------------------------------------------------
module sfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sfd_pkg::sfd_sts_t sts,
  output sfd_pkg::sfd_cmd_t cmd
);
  import sfd_pkg::*;

  sfd_state_t state_r, state_nxt;

  // Next state. A completed frame always passes through a read cycle, as its
  // empty flag is only registered at the edge that takes the closing byte.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.frame_end) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          state_nxt = (sts.empty || sts.idx_last) ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs and commands.
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.accept  = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.idx_inc = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_SHOW: begin
        out_valid   = 1'b1;
        cmd.idx_inc = out_ready && !sts.empty && !sts.idx_last;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/serial_frame_deframer_unit.sv
// ---------------------------------------------------------------------------
// Serial frame deframer
// Collects received serial bytes into frames and emits each payload byte.
// ---------------------------------------------------------------------------
// Bytes enter on the in_ channel, one item per byte. While no frame is being
// delivered, in_ready is high and an item is taken whenever in_valid is high. Two 0xEF
// bytes in a row restart the frame; a 0xFF byte at the position given by the
// length byte at offset 5 completes it.
// A completed frame gives one out_ item per payload byte (offsets 8 to
// length-2), each carrying the header fields, with out_last on the final one.
// A frame without payload gives a single item with out_payload_valid low.
// After the closing byte is taken, each result is first read from the frame
// buffer and then presented, as the buffer has a single read port. in_ready
// stays low until the last result of the frame has been taken.
// If out_ready stays low the current result is held and no byte is taken.
// A frame that fills the buffer without ending is dropped silently.
// Reset clears the fill count and returns to intake; the buffer keeps its
// contents, which are never read before being written.
// ---------------------------------------------------------------------------
module serial_frame_deframer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_reserved_byte,
  output logic [7:0] out_addr_first,
  output logic [7:0] out_addr_second,
  output logic [7:0] out_frame_length,
  output logic [7:0] out_node_id,
  output logic [7:0] out_device_id,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_payload_index,
  output logic       out_payload_valid,
  output logic       out_last
);
  import sfd_pkg::*;

  sfd_cmd_t cmd;
  sfd_sts_t sts;

  // Controller.
  sfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  sfd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_rx_byte    (in_rx_byte),
    .cmd           (cmd),
    .sts           (sts),
    .reserved_byte (out_reserved_byte),
    .addr_first    (out_addr_first),
    .addr_second   (out_addr_second),
    .frame_length  (out_frame_length),
    .node_id       (out_node_id),
    .device_id     (out_device_id),
    .payload_byte  (out_payload_byte),
    .payload_index (out_payload_index),
    .payload_valid (out_payload_valid),
    .last          (out_last)
  );

  // Checks on intake and readout sequencing.
`include "serial_frame_deframer_unit_assert.svh"

  `SFD_ASSERT_NOW(a_no_intake_while_showing, out_valid, !in_ready)
  `SFD_ASSERT_NOW(a_empty_is_last, out_valid && !out_payload_valid, out_last)
  `SFD_ASSERT_NEXT(a_intake_after_last, out_valid && out_ready && out_last, in_ready)

endmodule
